// ===== design/jse_pkg.sv =====
// Package: shared types, constants and escape helpers for the JSON string escaper.
package jse_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 12;
  localparam int unsigned CAP_WIDTH       = 12;
  localparam int unsigned LEN_WIDTH       = 12;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam logic [CAP_WIDTH-1:0] CAP_RESET = 12'd255;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_U      = 8'h75;

  typedef enum logic [1:0] {
    KIND_LITERAL,
    KIND_SHORT,
    KIND_UNICODE
  } esc_kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_req_t;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic                 is_status;
    logic                 run_last;
    logic                 overflowed;
    logic [LEN_WIDTH-1:0] out_length;
  } out_req_t;

  // One classified request waiting for the back end.
  typedef struct packed {
    logic       eos;
    esc_kind_e  kind;
    logic [7:0] data;
  } esc_entry_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = CH_ZERO + {4'd0, nib};
    end else begin
      r = CH_UPPER_A + {4'd0, nib} - 8'd10;
    end
    return r;
  endfunction

  function automatic logic [2:0] kind_last_idx(input esc_kind_e kind);
    logic [2:0] r;
    unique case (kind)
      KIND_LITERAL: r = 3'd0;
      KIND_SHORT:   r = 3'd1;
      KIND_UNICODE: r = 3'd5;
      default:      r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] esc_char(input esc_kind_e kind, input logic [7:0] data,
                                          input logic [2:0] idx);
    logic [7:0] r;
    r = data;
    unique case (kind)
      KIND_LITERAL: r = data;
      KIND_SHORT:   r = (idx == 3'd0) ? CH_BSLASH : data;
      KIND_UNICODE: begin
        unique case (idx)
          3'd0:    r = CH_BSLASH;
          3'd1:    r = CH_U;
          3'd2:    r = CH_ZERO;
          3'd3:    r = CH_ZERO;
          3'd4:    r = hex_char(data[7:4]);
          3'd5:    r = hex_char(data[3:0]);
          default: r = data;
        endcase
      end
      default: r = data;
    endcase
    return r;
  endfunction

endpackage

// ===== design/jse_front.sv =====
// Front end: accepts string bytes, classifies the escape, queues requests for the back end.
module jse_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  jse_pkg::in_req_t    in_data_i,
  output logic                head_valid_o,
  output jse_pkg::esc_entry_t head_o,
  input  logic                head_pop_i
);
  import jse_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

  esc_entry_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  esc_entry_t            cls;
  logic                  do_push, do_pop;

  always_comb begin
    cls.eos  = in_data_i.end_of_string;
    cls.data = in_data_i.in_byte;
    cls.kind = KIND_LITERAL;
    priority case (in_data_i.in_byte)
      CH_QUOTE:  cls.kind = KIND_SHORT;
      CH_BSLASH: cls.kind = KIND_SHORT;
      CH_LF: begin
        cls.kind = KIND_SHORT;
        cls.data = CH_N;
      end
      CH_CR: begin
        cls.kind = KIND_SHORT;
        cls.data = CH_R;
      end
      CH_TAB: begin
        cls.kind = KIND_SHORT;
        cls.data = CH_T;
      end
      CH_BS: begin
        cls.kind = KIND_SHORT;
        cls.data = CH_B;
      end
      CH_FF: begin
        cls.kind = KIND_SHORT;
        cls.data = CH_F;
      end
      default: begin
        if (in_data_i.in_byte < CH_SPACE) begin
          cls.kind = KIND_UNICODE;
        end
      end
    endcase
  end

  assign full_o       = (cnt_q == CntFull);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = head_pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ===== design/jse_back.sv =====
// Back end: steps through escape sequences, enforces capacity, drives the result register.
module jse_back #(
  parameter int unsigned COUNT_WIDTH = jse_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         head_valid_i,
  input  jse_pkg::esc_entry_t          head_i,
  output logic                         head_pop_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [jse_pkg::CAP_WIDTH-1:0] cfg_data_i,
  output logic                         empty_o,
  input  logic                         pop_i,
  output jse_pkg::out_req_t            out_data_o
);
  import jse_pkg::*;

  localparam int unsigned MaxW = (COUNT_WIDTH > CAP_WIDTH) ? COUNT_WIDTH : CAP_WIDTH;
  localparam int unsigned ExtW = MaxW + 2;
  localparam logic [ExtW-1:0] CntMax = ExtW'((64'd1 << COUNT_WIDTH) - 64'd1);

  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                   ovf_q, ovf_d;
  logic [2:0]             idx_q, idx_d;
  logic [CAP_WIDTH-1:0]   cap_q;
  out_req_t               out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  logic [ExtW-1:0] cnt_x, cap_x;
  logic            out_free, cur_fit, nxt_fit, is_last, load;
  logic [2:0]      last_idx;

  assign cnt_x    = ExtW'(cnt_q);
  assign cap_x    = ExtW'(cap_q);
  assign out_free = !out_valid_q || pop_i;
  assign cur_fit  = (cnt_x + ExtW'(1) < cap_x) && (cnt_x < CntMax);
  assign nxt_fit  = (cnt_x + ExtW'(2) < cap_x) && (cnt_x + ExtW'(1) < CntMax);
  assign last_idx = kind_last_idx(head_i.kind);
  assign is_last  = (idx_q == last_idx);

  always_comb begin
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    idx_d      = idx_q;
    out_d      = out_q;
    load       = 1'b0;
    head_pop_o = 1'b0;
    priority if (!head_valid_i) begin
      head_pop_o = 1'b0;
    end else if (head_i.eos) begin
      if (out_free) begin
        load             = 1'b1;
        head_pop_o       = 1'b1;
        out_d.out_byte   = '0;
        out_d.is_status  = 1'b1;
        out_d.run_last   = 1'b1;
        out_d.overflowed = ovf_q || (cnt_x >= cap_x);
        out_d.out_length = cnt_x[LEN_WIDTH-1:0];
        cnt_d            = '0;
        ovf_d            = 1'b0;
        idx_d            = '0;
      end
    end else if (ovf_q) begin
      head_pop_o = 1'b1;
      idx_d      = '0;
    end else if (!cur_fit) begin
      head_pop_o = 1'b1;
      ovf_d      = 1'b1;
      idx_d      = '0;
    end else if (out_free) begin
      load             = 1'b1;
      out_d.out_byte   = esc_char(head_i.kind, head_i.data, idx_q);
      out_d.is_status  = 1'b0;
      out_d.run_last   = is_last || !nxt_fit;
      out_d.overflowed = 1'b0;
      out_d.out_length = '0;
      cnt_d            = cnt_q + 1'b1;
      if (is_last || !nxt_fit) begin
        head_pop_o = 1'b1;
        idx_d      = '0;
        ovf_d      = !is_last;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign empty_o     = !out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== design/json_string_escaper_top.sv =====
// Top level: JSON string escaper, classifying front end and escape-sequencing back end.
//
//  channel   direction  handshake              payload
//  input     in         push_i / full_o        in_data_i  (in_byte, end_of_string)
//  result    out        pop_i / empty_o        out_data_o (out_byte, is_status, run_last,
//                                                          overflowed, out_length)
//  config    in         cfg_valid_i / _ready_o cfg_data_i (out_capacity)
//
// Plain bytes and status requests give one result each, short escapes two, \u00XX escapes six.
// The back end emits one result byte per cycle while the result register is free or popped.
// An accepted request passes the queue, then the result register, before its first result shows.
// A 2-entry queue between front and back absorbs escape drain; full_o rises while it is full.
// Reset clears queue, counters, sticky overflow, and sets the capacity to 255.
// A stalled result register holds the back end; dropped bytes after overflow drain freely.
module json_string_escaper_top #(
  parameter int unsigned COUNT_WIDTH = jse_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  jse_pkg::in_req_t              in_data_i,
  output logic                          empty_o,
  input  logic                          pop_i,
  output jse_pkg::out_req_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [jse_pkg::CAP_WIDTH-1:0] cfg_data_i
);
  import jse_pkg::*;

  logic       head_valid;
  esc_entry_t head;
  logic       head_pop;

  jse_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .in_data_i    (in_data_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .head_pop_i   (head_pop)
  );

  jse_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== design/jse_checker.sv =====
// Checker: port-level properties of the JSON string escaper, bound to the top level.
module jse_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          empty_o,
  input logic                          pop_i,
  input jse_pkg::out_req_t             out_data_o
);
  import jse_pkg::*;

  logic out_shown;
  assign out_shown = !empty_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_shown && !pop_i) |=> (out_shown && $stable(out_data_o)))
    else $error("result changed while stalled");

  a_status_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_shown && out_data_o.is_status) |->
      (out_data_o.run_last && out_data_o.out_byte == 8'd0))
    else $error("status request malformed");

  a_byte_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_shown && !out_data_o.is_status) |->
      (!out_data_o.overflowed && out_data_o.out_length == '0))
    else $error("byte request carries status fields");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_shown && out_data_o.is_status) |-> (out_data_o.out_length != '1))
    else $error("reported length exceeds capacity range");

endmodule

bind json_string_escaper_top jse_checker u_jse_checker (.*);

// ===== tb/jse_escape_checker.sv =====
// Checker: predicts the escaped byte stream and status requests, compares popped results.
module jse_escape_checker
  import jse_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic                 full_i,
  input  in_req_t              in_data_i,
  input  logic                 empty_i,
  input  logic                 pop_i,
  input  out_req_t             out_data_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CAP_WIDTH-1:0] cfg_data_i,
  output int                   pending_o,
  output int                   errors_o
);

  localparam int COUNT_MAX = (1 << COUNT_WIDTH_DEF) - 1;

  logic [CAP_WIDTH-1:0]       capacity;
  logic [COUNT_WIDTH_DEF-1:0] emitted;
  logic                       overflow_flag;
  out_req_t                   due_chars_q[$];
  out_req_t                   want;
  int                         err_count = 0;

  assign errors_o = err_count;

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CH_ZERO + 8'(nib);
    end
    return CH_UPPER_A + 8'(nib) - 8'd10;
  endfunction

  task automatic predict_escape(input logic [7:0] b);
    logic [7:0] seq [6];
    logic [7:0] code;
    int         seq_len;
    int         fit;
    out_req_t   r;
    case (b)
      CH_QUOTE, CH_BSLASH: code = b;
      CH_LF:               code = CH_N;
      CH_CR:               code = CH_R;
      CH_TAB:              code = CH_T;
      CH_BS:               code = CH_B;
      CH_FF:               code = CH_F;
      default:             code = 8'h00;
    endcase
    seq[0]  = b;
    seq_len = 1;
    if (code != 8'h00) begin
      seq[0]  = CH_BSLASH;
      seq[1]  = code;
      seq_len = 2;
    end else if (b < CH_SPACE) begin
      seq[0]  = CH_BSLASH;
      seq[1]  = CH_U;
      seq[2]  = CH_ZERO;
      seq[3]  = CH_ZERO;
      seq[4]  = hex_ascii(b[7:4]);
      seq[5]  = hex_ascii(b[3:0]);
      seq_len = 6;
    end
    // one place is kept for the terminator
    fit = 0;
    while (fit < seq_len && int'(emitted) + fit + 1 < int'(capacity) &&
           int'(emitted) + fit < COUNT_MAX) begin
      fit++;
    end
    for (int i = 0; i < fit; i++) begin
      r          = '0;
      r.out_byte = seq[i];
      r.run_last = (i == fit - 1);
      due_chars_q.push_back(r);
    end
    if (fit < seq_len) begin
      overflow_flag = 1'b1;
    end
    emitted = emitted + COUNT_WIDTH_DEF'(fit);
  endtask

  task automatic close_string();
    out_req_t r;
    r            = '0;
    r.is_status  = 1'b1;
    r.run_last   = 1'b1;
    r.overflowed = overflow_flag || (emitted >= capacity);
    r.out_length = emitted;
    due_chars_q.push_back(r);
    emitted       = '0;
    overflow_flag = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [11:0] exp_val,
                             input logic [11:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, got_val);
      err_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity      = CAP_RESET;
      emitted       = '0;
      overflow_flag = 1'b0;
      due_chars_q.delete();
      pending_o <= 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (due_chars_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, out_data_i);
          err_count++;
        end else begin
          want = due_chars_q.pop_front();
          check_field("out_byte", 12'(want.out_byte), 12'(out_data_i.out_byte));
          check_field("is_status", 12'(want.is_status), 12'(out_data_i.is_status));
          check_field("run_last", 12'(want.run_last), 12'(out_data_i.run_last));
          check_field("overflowed", 12'(want.overflowed), 12'(out_data_i.overflowed));
          check_field("out_length", want.out_length, out_data_i.out_length);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        capacity = cfg_data_i;
      end
      if (push_i && !full_i) begin
        if (in_data_i.end_of_string) begin
          close_string();
        end else if (!overflow_flag) begin
          predict_escape(in_data_i.in_byte);
        end
      end
      pending_o <= due_chars_q.size();
    end
  end

endmodule

// ===== tb/tb_json_string_escaper_top.sv =====
// Testbench top: drives directed and random strings into the JSON string escaper.
module tb_json_string_escaper_top;
  import jse_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 185;
  localparam logic [7:0] DIRECTED_BYTES [15] = '{
    CH_QUOTE, CH_BSLASH, CH_LF, CH_CR, CH_TAB, CH_BS, CH_FF, 8'h00, 8'h1F, 8'h0B,
    CH_SPACE, CH_UPPER_A, 8'h7F, 8'h80, 8'hFF
  };

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 push      = 1'b0;
  in_req_t              in_data   = '0;
  logic                 pop       = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CAP_WIDTH-1:0] cfg_data  = '0;
  logic                 full;
  logic                 empty;
  logic                 cfg_ready;
  out_req_t             out_data;
  int                   pending;
  int                   errors;
  int                   stall_cycles  = 0;
  int                   burst_left    = 0;
  int                   pop_mode      = 0;
  int                   pop_mode_left = 0;
  int                   random_items  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  json_string_escaper_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push_i      (push),
    .full_o      (full),
    .in_data_i   (in_data),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  jse_escape_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push_i      (push),
    .full_i      (full),
    .in_data_i   (in_data),
    .empty_i     (empty),
    .pop_i       (pop),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_json_string_escaper_top: done, errors");
      $finish;
    end
  end

  // receiver: free-running, coin-flip, mostly stalled or mostly popping
  always @(negedge clk) begin
    if (pop_mode_left == 0) begin
      pop_mode      = $urandom_range(0, 3);
      pop_mode_left = $urandom_range(8, 64);
    end
    pop_mode_left--;
    case (pop_mode)
      0:       pop <= 1'b1;
      1:       pop <= 1'($urandom_range(0, 1));
      2:       pop <= ($urandom_range(0, 3) == 0);
      default: pop <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic send_req(input logic [7:0] b, input logic eos);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      repeat (gap) begin
        @(negedge clk);
        push <= 1'b0;
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    push    <= 1'b1;
    in_data <= '{in_byte: b, end_of_string: eos};
    do @(posedge clk); while (full);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_WIDTH-1:0] cap);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_string_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1: b = 8'($urandom_range(0, 31));
      2: begin
        case ($urandom_range(0, 6))
          0:       b = CH_QUOTE;
          1:       b = CH_BSLASH;
          2:       b = CH_LF;
          3:       b = CH_CR;
          4:       b = CH_TAB;
          5:       b = CH_BS;
          default: b = CH_FF;
        endcase
      end
      3, 4, 5, 6: b = 8'($urandom_range(32, 126));
      default:    b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  task automatic send_string(input int len, input logic close);
    for (int i = 0; i < len; i++) begin
      send_req(pick_string_byte(), 1'b0);
    end
    if (close) begin
      send_req(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  initial begin
    int                   n_str;
    int                   len;
    logic                 close;
    logic [CAP_WIDTH-1:0] cap;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_BYTES[i]) begin
      send_req(DIRECTED_BYTES[i], 1'b0);
    end
    send_req(8'hFF, 1'b1);
    write_capacity('0);
    send_req(8'h00, 1'b1);
    // unicode escape cut short, then a dropped byte
    write_capacity(12'd4);
    send_req(8'h00, 1'b0);
    send_req(CH_UPPER_A, 1'b0);
    send_req(8'h00, 1'b1);
    write_capacity(12'd1);
    send_req(CH_UPPER_A, 1'b0);
    send_req(8'h00, 1'b1);
    // capacity lowered mid-string
    write_capacity(CAP_RESET);
    send_req(CH_UPPER_A, 1'b0);
    send_req(8'h42, 1'b0);
    write_capacity(12'd1);
    send_req(8'h00, 1'b1);

    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:          cap = 12'($urandom_range(0, 3));
        1, 2, 3, 4: cap = 12'($urandom_range(4, 40));
        5, 6, 7:    cap = 12'($urandom_range(41, 300));
        8:          cap = CAP_RESET;
        default:    cap = 12'hFFF;
      endcase
      write_capacity(cap);
      n_str = $urandom_range(1, 4);
      for (int s = 0; s < n_str; s++) begin
        len   = $urandom_range(0, 12);
        close = !(s == n_str - 1 && $urandom_range(0, 3) == 0);
        send_string(len, close);
        random_items += len + int'(close);
      end
    end

    wait_drained();
    @(negedge clk);
    if (errors == 0) begin
      $display("tb_json_string_escaper_top: done, clean");
    end else begin
      $display("tb_json_string_escaper_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/jse_pkg.sv
design/jse_front.sv
design/jse_back.sv
design/json_string_escaper_top.sv
design/jse_checker.sv
tb/jse_escape_checker.sv
tb/tb_json_string_escaper_top.sv
